// ----- rtl/lzw_pkg.sv -----
`default_nettype none

package lzw_pkg;

    // Widest code the block can be built for; code fields between modules use this width.
    localparam int CODE_W_MAX = 16;

    // Width of the epoch tag kept with every dictionary entry.
    localparam int EPOCH_W = 6;

    // Most codes that one input request can produce.
    localparam int SLOTS = 4;

    typedef logic [CODE_W_MAX-1:0] code_t;
    typedef logic [4:0]            cwidth_t;

    localparam code_t   CLEAR_CODE  = 16'h0100;
    localparam code_t   END_CODE    = 16'h0101;
    localparam code_t   FIRST_CODE  = 16'h0102;
    localparam code_t   FIRST_LIMIT = 16'h0200;
    localparam cwidth_t FIRST_WIDTH = 5'd9;

    // The codes that one input request sends, in order, each with its width.
    typedef struct packed {
        code_t   [SLOTS-1:0] code;
        cwidth_t [SLOTS-1:0] width;
        logic    [2:0]       count;
        logic                fin;
    } group_t;

endpackage

`default_nettype wire

// ----- rtl/lzw_in_if.sv -----
`default_nettype none

interface lzw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/lzw_out_if.sv -----
`default_nettype none

interface lzw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       stream_end;

    modport source (output valid, output out_byte, output stream_end, input ready);
    modport sink   (input valid, input out_byte, input stream_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/lzw_compressor_variable_width_top.sv -----
`default_nettype none

// Variable-width LZW compressor. Each request on the data channel carries one
// uncompressed byte and a last-byte mark; the codes channel returns the LZW code
// stream, packed LSB-first into bytes, with stream_end set on the final byte of a
// stream. A stream opens with a clear code, codes start at 9 bits and grow up to
// MAX_CODE_BITS, a clear code is sent and the dictionary restarted when it fills,
// and the last byte sends the open prefix, the end code and any partial byte.
// After the last byte the block is back in its start-of-stream state, so the next byte
// starts a new stream. Throughput: one byte is accepted per cycle while the
// output side keeps up; each byte is read from the dictionary memory in the
// cycle it is accepted and is resolved and written back in the next, and the
// lookup of one byte overlaps the resolve of the one before it, with the new
// prefix fed straight to the read address and the previous write forwarded.
// The output sends one byte per cycle while codes.ready is high, so a byte
// that produces more than one output byte holds the input back once the small
// code queue is full. The dictionary holds 2^(MAX_CODE_BITS+8) entries in one
// RAM, each tagged with a 6-bit epoch so that clearing it only moves to a fresh
// epoch. While the epoch counter sits at its last value, a byte is not taken
// while the one before it is in the lookup stage, so that a stream end or a
// dictionary clear in the lookup stage can start the clearing pass before the
// next byte is read. After reset, and again after every 63rd dictionary
// clear (a stream end counts as one), the block runs a clearing pass over all
// 2^(MAX_CODE_BITS+8) entries (1048576 at the default of 12); data.ready stays low.

module lzw_compressor_variable_width_top #(
    parameter int MAX_CODE_BITS = 12
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lzw_in_if.sink     data,
    lzw_out_if.source  codes
);

    // Codes of one request travel from the dictionary stage to the bit packer as a group.
    lzw_pkg::group_t grp;
    logic            grp_valid;
    logic            grp_room;

    lzw_lookup #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_lookup (
        .clk       (clk),
        .rst_n     (rst_n),
        .data      (data),
        .grp       (grp),
        .grp_valid (grp_valid),
        .grp_room  (grp_room)
    );

    lzw_packer #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp       (grp),
        .grp_valid (grp_valid),
        .grp_room  (grp_room),
        .codes     (codes)
    );

endmodule

`default_nettype wire

// ----- rtl/lzw_ram.sv -----
`default_nettype none

module lzw_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1048576
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/lzw_lookup.sv -----
`default_nettype none

module lzw_lookup #(
    parameter int MAX_CODE_BITS = 12
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    lzw_in_if.sink             data,
    output lzw_pkg::group_t    grp,
    output logic               grp_valid,
    input  wire logic          grp_room
);

    localparam int CODE_W  = MAX_CODE_BITS;
    localparam int NEXT_W  = MAX_CODE_BITS + 1;
    localparam int ADDR_W  = MAX_CODE_BITS + 8;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int TAG_W   = lzw_pkg::EPOCH_W;
    localparam int ENTRY_W = TAG_W + CODE_W;
    localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
    localparam logic [TAG_W-1:0] TAG_LAST  = '1;

    logic                 started_reg, started_next;
    logic [CODE_W-1:0]    prefix_reg, prefix_next;
    logic [NEXT_W-1:0]    next_code_reg, next_code_next;
    logic [NEXT_W-1:0]    limit_reg, limit_next;
    lzw_pkg::cwidth_t     width_reg, width_next;
    logic [TAG_W-1:0]     epoch_reg, epoch_next;
    logic                 sweep_reg, sweep_next;
    logic [ADDR_W-1:0]    sweep_addr_reg, sweep_addr_next;

    logic                 b_valid_reg, b_valid_next;
    logic [7:0]           b_byte_reg, b_byte_next;
    logic                 b_last_reg, b_last_next;
    logic                 b_first_reg, b_first_next;
    logic [ADDR_W-1:0]    b_addr_reg, b_addr_next;

    logic                 fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0]    fwd_addr_reg, fwd_addr_next;
    logic [TAG_W-1:0]     fwd_tag_reg, fwd_tag_next;
    logic [CODE_W-1:0]    fwd_code_reg, fwd_code_next;

    logic [ENTRY_W-1:0]   rdata;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [ENTRY_W-1:0]   wdata;
    logic [ADDR_W-1:0]    raddr;

    logic [TAG_W-1:0]     entry_tag;
    logic [CODE_W-1:0]    entry_code;
    logic                 hit, miss, grow, wrap, bump;
    logic [CODE_W-1:0]    prefix_item;
    logic [NEXT_W-1:0]    next_code_item, limit_item;
    lzw_pkg::cwidth_t     width_item;
    logic                 started_eff;
    logic [CODE_W-1:0]    prefix_eff;
    logic                 accept;
    lzw_pkg::group_t      grp_c;
    logic [2:0]           n;

    lzw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_dict (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // The entry written in the previous cycle is not yet in the read data.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == b_addr_reg))
        begin
            entry_tag  = fwd_tag_reg;
            entry_code = fwd_code_reg;
        end
        else
        begin
            entry_tag  = rdata[ENTRY_W-1:CODE_W];
            entry_code = rdata[CODE_W-1:0];
        end
    end

    assign hit  = !b_first_reg && (entry_tag == epoch_reg);
    assign miss = !b_first_reg && !hit;
    assign grow = miss && (next_code_reg >= limit_reg);
    assign wrap = grow && (width_reg == lzw_pkg::cwidth_t'(MAX_CODE_BITS));

    always_comb
    begin
        prefix_item    = hit ? entry_code : CODE_W'(b_byte_reg);
        next_code_item = miss ? (next_code_reg + NEXT_W'(1)) : next_code_reg;
        limit_item     = limit_reg;
        width_item     = width_reg;
        if (wrap)
        begin
            next_code_item = NEXT_W'(lzw_pkg::FIRST_CODE);
            limit_item     = NEXT_W'(lzw_pkg::FIRST_LIMIT);
            width_item     = lzw_pkg::FIRST_WIDTH;
        end
        else if (grow)
        begin
            limit_item = limit_reg << 1;
            width_item = width_reg + lzw_pkg::cwidth_t'(1);
        end
    end

    // Codes sent for the request in the lookup stage.
    always_comb
    begin
        grp_c = '0;
        n     = '0;
        if (b_first_reg)
        begin
            grp_c.code[n[1:0]]  = lzw_pkg::CLEAR_CODE;
            grp_c.width[n[1:0]] = width_reg;
            n = n + 3'd1;
        end
        else if (miss)
        begin
            grp_c.code[n[1:0]]  = lzw_pkg::code_t'(prefix_reg);
            grp_c.width[n[1:0]] = width_reg;
            n = n + 3'd1;
            if (wrap)
            begin
                grp_c.code[n[1:0]]  = lzw_pkg::CLEAR_CODE;
                grp_c.width[n[1:0]] = width_reg;
                n = n + 3'd1;
            end
        end
        if (b_last_reg)
        begin
            grp_c.code[n[1:0]]  = lzw_pkg::code_t'(prefix_item);
            grp_c.width[n[1:0]] = width_item;
            n = n + 3'd1;
            grp_c.code[n[1:0]]  = lzw_pkg::END_CODE;
            grp_c.width[n[1:0]] = width_item;
            n = n + 3'd1;
        end
        grp_c.count = n;
        grp_c.fin   = b_last_reg;
    end

    assign grp       = grp_c;
    assign grp_valid = b_valid_reg && (n != 3'd0);

    assign started_eff = b_valid_reg ? !b_last_reg : started_reg;
    assign prefix_eff  = b_valid_reg ? prefix_item : prefix_reg;

    assign data.ready = !sweep_reg && grp_room && !(b_valid_reg && (epoch_reg == TAG_LAST));
    assign accept     = data.valid && data.ready;

    assign raddr = {prefix_eff, data.data_byte};
    assign we    = sweep_reg || (b_valid_reg && miss);
    assign waddr = sweep_reg ? sweep_addr_reg : b_addr_reg;
    assign wdata = sweep_reg ? '0 : {epoch_reg, next_code_reg[CODE_W-1:0]};

    assign bump = b_valid_reg && (wrap || b_last_reg);

    always_comb
    begin
        started_next    = started_reg;
        prefix_next     = prefix_reg;
        next_code_next  = next_code_reg;
        limit_next      = limit_reg;
        width_next      = width_reg;
        epoch_next      = epoch_reg;
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;

        if (sweep_reg)
        begin
            sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
            if (sweep_addr_reg == '1)
            begin
                sweep_next = 1'b0;
            end
        end

        if (b_valid_reg)
        begin
            started_next   = !b_last_reg;
            prefix_next    = prefix_item;
            next_code_next = next_code_item;
            limit_next     = limit_item;
            width_next     = width_item;
            if (b_last_reg)
            begin
                prefix_next    = '0;
                next_code_next = NEXT_W'(lzw_pkg::FIRST_CODE);
                limit_next     = NEXT_W'(lzw_pkg::FIRST_LIMIT);
                width_next     = lzw_pkg::FIRST_WIDTH;
            end
        end

        // A dictionary clear moves to a fresh epoch; the tags are swept only when the epoch counter wraps.
        if (bump)
        begin
            if (epoch_reg == TAG_LAST)
            begin
                epoch_next      = TAG_FIRST;
                sweep_next      = 1'b1;
                sweep_addr_next = '0;
            end
            else
            begin
                epoch_next = epoch_reg + TAG_W'(1);
            end
        end
    end

    always_comb
    begin
        b_valid_next   = accept;
        b_byte_next    = data.data_byte;
        b_last_next    = data.last_byte;
        b_first_next   = !started_eff;
        b_addr_next    = raddr;
        fwd_valid_next = b_valid_reg && miss;
        fwd_addr_next  = b_addr_reg;
        fwd_tag_next   = epoch_reg;
        fwd_code_next  = next_code_reg[CODE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            prefix_reg     <= '0;
            next_code_reg  <= NEXT_W'(lzw_pkg::FIRST_CODE);
            limit_reg      <= NEXT_W'(lzw_pkg::FIRST_LIMIT);
            width_reg      <= lzw_pkg::FIRST_WIDTH;
            epoch_reg      <= TAG_FIRST;
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            started_reg    <= started_next;
            prefix_reg     <= prefix_next;
            next_code_reg  <= next_code_next;
            limit_reg      <= limit_next;
            width_reg      <= width_next;
            epoch_reg      <= epoch_next;
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
            b_valid_reg    <= b_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_byte_reg   <= b_byte_next;
        b_last_reg   <= b_last_next;
        b_first_reg  <= b_first_next;
        b_addr_reg   <= b_addr_next;
        fwd_addr_reg <= fwd_addr_next;
        fwd_tag_reg  <= fwd_tag_next;
        fwd_code_reg <= fwd_code_next;
    end

endmodule

`default_nettype wire

// ----- rtl/lzw_packer.sv -----
`default_nettype none

module lzw_packer #(
    parameter int MAX_CODE_BITS = 12
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lzw_pkg::group_t  grp,
    input  wire logic             grp_valid,
    output logic                  grp_room,
    lzw_out_if.source             codes
);

    localparam int CODE_W     = MAX_CODE_BITS;
    localparam int ACC_W      = MAX_CODE_BITS + 7;
    localparam int CNT_W      = $clog2(ACC_W + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    lzw_pkg::group_t     fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]   fcount_reg, fcount_next;
    logic [1:0]          slot_reg, slot_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                fin_reg, fin_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_end_reg, out_end_next;

    lzw_pkg::group_t     head;
    lzw_pkg::cwidth_t    w;
    logic [ACC_W-1:0]    code_ext;
    logic [ACC_W-1:0]    mask;
    logic                can_out, emit_full, emit_flush, take, pop, push;
    logic [ACC_W-1:0]    acc_s;
    logic [CNT_W-1:0]    cnt_s;

    assign head     = fifo_mem[rd_ptr_reg];
    assign w        = head.width[slot_reg];
    assign code_ext = ACC_W'(head.code[slot_reg][CODE_W-1:0]);
    assign mask     = ~({ACC_W{1'b1}} << w);

    assign can_out    = !out_valid_reg || codes.ready;
    assign emit_full  = can_out && (cnt_reg >= CNT_W'(8));
    assign emit_flush = can_out && fin_reg && (cnt_reg < CNT_W'(8)) && (cnt_reg != '0);

    assign acc_s = emit_full ? (acc_reg >> 8) : (emit_flush ? '0 : acc_reg);
    assign cnt_s = emit_full ? (cnt_reg - CNT_W'(8)) : (emit_flush ? '0 : cnt_reg);

    assign take = !fin_reg && (fcount_reg != '0) && (cnt_s < CNT_W'(8));
    assign pop  = take && ({1'b0, slot_reg} == (head.count - 3'd1));
    assign push = grp_valid;

    // Room for the group in the lookup stage and one more behind it.
    assign grp_room = fcount_reg <= FCNT_W'(FIFO_DEPTH - 2);

    always_comb
    begin
        acc_next       = acc_s;
        cnt_next       = cnt_s;
        slot_next      = slot_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;

        if (emit_full || emit_flush)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = acc_reg[7:0];
            out_end_next   = fin_reg && (emit_flush || (cnt_reg == CNT_W'(8)));
            if (out_end_next)
            begin
                fin_next = 1'b0;
            end
        end
        else if (codes.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (fin_reg && (cnt_reg == '0))
        begin
            fin_next = 1'b0;
        end

        if (take)
        begin
            acc_next = acc_s | ((code_ext & mask) << cnt_s);
            cnt_next = cnt_s + CNT_W'(w);
            if (pop)
            begin
                slot_next = '0;
                fin_next  = head.fin;
            end
            else
            begin
                slot_next = slot_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        fcount_next = fcount_reg + FCNT_W'(push) - FCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= grp;
        end
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            fcount_reg    <= '0;
            slot_reg      <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            fcount_reg    <= fcount_next;
            slot_reg      <= slot_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign codes.valid      = out_valid_reg;
    assign codes.out_byte   = out_byte_reg;
    assign codes.stream_end = out_end_reg;

endmodule

`default_nettype wire

// ----- tb/sv/tb_lzw_compressor_variable_width_top.sv -----
`timescale 1ns / 1ps

// Testbench for the variable-width LZW compressor.
//
// Byte requests go into the data channel and the packed code bytes coming out
// of the codes channel are compared, one by one, with the bytes that a
// behavioral model of the compressor predicts. The model lives in a small
// scoreboard class: it keeps its own dictionary, prefix, code counter, width
// and bit packer, and it turns each accepted input request into the list of
// output bytes that the request must cause.
module tb_lzw_compressor_variable_width_top;

    // Build-time width limit of the block under test.
    localparam int DUT_CODE_BITS = 12;

    // No single input request can cause more output bytes than this.
    localparam int MAX_RESULTS = 8;

    // Quiet cycles allowed after the last expected byte, so that a stray extra
    // byte still has time to show up and be flagged.
    localparam int TAIL_CYCLES = 64;

    // The block runs a clearing pass over all 2^(DUT_CODE_BITS+8) dictionary
    // entries after reset and again after every 63rd dictionary clear. The limit
    // allows for several of those passes on top of a slow, heavily stalled run.
    localparam int LIMIT_CYCLES = 8_000_000;

    // One byte of the packed code stream, as it leaves the block.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       stream_end;
    } code_byte_t;

    // Behavioral model of the compressor plus the queue of output bytes that
    // are still owed by the block.
    class lzw_code_tracker;
        bit [DUT_CODE_BITS:0]   dict_code [bit [DUT_CODE_BITS+7:0]];
        bit [DUT_CODE_BITS-1:0] prefix;
        bit [DUT_CODE_BITS:0]   next_code;
        bit [DUT_CODE_BITS:0]   code_limit;
        bit [4:0]               width;
        bit [7:0]               pend_bits;
        bit [2:0]               pend_cnt;
        bit                     started;

        code_byte_t step_bytes[$];
        code_byte_t owed_bytes[$];
        int         error_count;

        function new();
            error_count = 0;
            reset_stream();
        endfunction

        // An empty associative array stands for a dictionary with every entry
        // empty, so clearing it is a single delete.
        function void restart_table();
            dict_code.delete();
            next_code  = lzw_pkg::FIRST_CODE[DUT_CODE_BITS:0];
            code_limit = lzw_pkg::FIRST_LIMIT[DUT_CODE_BITS:0];
            width      = lzw_pkg::FIRST_WIDTH;
        endfunction

        function void reset_stream();
            restart_table();
            prefix    = '0;
            pend_bits = '0;
            pend_cnt  = '0;
            started   = 1'b0;
        endfunction

        // Appends one code at the current width to the LSB-first bit stream
        // and collects every byte that becomes complete.
        function void pack_code(bit [15:0] code);
            bit [31:0]   acc;
            int unsigned cnt;
            code_byte_t  rec;
            acc = {24'd0, pend_bits}
                | ((32'(code) & ((32'd1 << width) - 32'd1)) << pend_cnt);
            cnt = pend_cnt + width;
            while (cnt >= 8)
            begin
                if (step_bytes.size() < MAX_RESULTS)
                begin
                    rec.out_byte   = acc[7:0];
                    rec.stream_end = 1'b0;
                    step_bytes.push_back(rec);
                end
                acc = acc >> 8;
                cnt = cnt - 8;
            end
            pend_bits = acc[7:0];
            pend_cnt  = cnt[2:0];
        endfunction

        // Notes one accepted input request and queues the bytes it causes.
        function void note_data_byte(bit [7:0] data_val, bit last_val);
            bit [DUT_CODE_BITS+7:0] key;
            code_byte_t             rec;
            step_bytes.delete();
            if (!started)
            begin
                pack_code(lzw_pkg::CLEAR_CODE);
                prefix  = DUT_CODE_BITS'(data_val);
                started = 1'b1;
            end
            else
            begin
                key = {prefix, data_val};
                if (dict_code.exists(key))
                begin
                    prefix = dict_code[key][DUT_CODE_BITS-1:0];
                end
                else
                begin
                    pack_code(16'(prefix));
                    dict_code[key] = next_code;
                    next_code      = next_code + 1'b1;
                    prefix         = DUT_CODE_BITS'(data_val);
                    if (next_code > code_limit)
                    begin
                        if (width < DUT_CODE_BITS)
                        begin
                            code_limit = code_limit << 1;
                            width      = width + 1'b1;
                        end
                        else
                        begin
                            // The table is full: the clear code goes out at the
                            // full width, then everything starts over at 9 bits.
                            pack_code(lzw_pkg::CLEAR_CODE);
                            restart_table();
                        end
                    end
                end
            end
            if (last_val)
            begin
                pack_code(16'(prefix));
                pack_code(lzw_pkg::END_CODE);
                if (pend_cnt != 0 && step_bytes.size() < MAX_RESULTS)
                begin
                    rec.out_byte   = pend_bits;
                    rec.stream_end = 1'b0;
                    step_bytes.push_back(rec);
                end
                if (step_bytes.size() > 0)
                begin
                    rec = step_bytes.pop_back();
                    rec.stream_end = 1'b1;
                    step_bytes.push_back(rec);
                end
                reset_stream();
            end
            foreach (step_bytes[i])
                owed_bytes.push_back(step_bytes[i]);
        endfunction

        // Compares one accepted output byte with the oldest owed byte.
        function void check_code_byte(bit [7:0] out_val, bit end_val);
            code_byte_t want;
            if (owed_bytes.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected output byte: expected none, actual %02h end %0b",
                         $time, out_val, end_val);
            end
            else
            begin
                want = owed_bytes.pop_front();
                if (want.out_byte != out_val)
                begin
                    error_count++;
                    $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                             $time, want.out_byte, out_val);
                end
                if (want.stream_end != end_val)
                begin
                    error_count++;
                    $display("%0t: stream_end mismatch: expected %0b, actual %0b",
                             $time, want.stream_end, end_val);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    lzw_in_if  data_if ();
    lzw_out_if codes_if ();

    lzw_compressor_variable_width_top #(
        .MAX_CODE_BITS(DUT_CODE_BITS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .data  (data_if),
        .codes (codes_if)
    );

    lzw_code_tracker tracker;

    // Chance, in percent, that the sender or the receiver idles in a cycle.
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;

    // Alphabet used by streams with few distinct symbols; these hit the
    // dictionary often and build long prefix chains.
    bit [7:0] alphabet [4];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Every input of the block has a known value from time zero.
    initial
    begin
        rst_n              = 1'b0;
        data_if.valid      = 1'b0;
        data_if.data_byte  = 8'd0;
        data_if.last_byte  = 1'b0;
        codes_if.ready     = 1'b0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        tracker            = new();
    end

    // Watchdog: a run that reaches the limit has hung somewhere.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL lzw_compressor_variable_width_top");
        $finish;
    end

    // The receiver decides at each falling edge whether it takes a byte at the
    // next rising edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            codes_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Output bytes are sampled at the rising edge, where they are stable.
    always @(posedge clk)
    begin
        if (rst_n && codes_if.valid === 1'b1 && codes_if.ready === 1'b1)
            tracker.check_code_byte(codes_if.out_byte, codes_if.stream_end);
    end

    // Sends one request. It is entered at a falling edge, right after the
    // previous request was accepted, and returns at the falling edge after
    // this one is accepted. Valid is touched at most once per falling edge.
    task automatic send_request(input bit [7:0] data_val, input bit last_val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            data_if.valid <= 1'b0;
            @(negedge clk);
        end
        data_if.valid     <= 1'b1;
        data_if.data_byte <= data_val;
        data_if.last_byte <= last_val;
        do
            @(posedge clk);
        while (data_if.ready !== 1'b1);
        tracker.note_data_byte(data_val, last_val);
        @(negedge clk);
    endtask

    // Holds the sender off until every owed byte has come out, then waits out a
    // quiet tail for anything the block still has in flight.
    task automatic wait_for_drain();
        data_if.valid <= 1'b0;
        while (tracker.owed_bytes.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Sends one stream of the given length. Mode 0 draws bytes over the whole
    // range, mode 1 draws from a four-symbol alphabet, mode 2 makes runs of
    // repeated bytes. When pause_at is not negative, the sender stops before
    // that byte until the block has delivered all it owes.
    task automatic send_stream(input int len, input int mode, input int pause_at);
        bit [7:0] data_val;
        data_val = 8'($urandom_range(255));
        for (int k = 0; k < 4; k++)
            alphabet[k] = 8'($urandom_range(255));
        for (int i = 0; i < len; i++)
        begin
            if (i == pause_at)
                wait_for_drain();
            case (mode)
                0: data_val = 8'($urandom_range(255));
                1: data_val = alphabet[$urandom_range(3)];
                default:
                begin
                    if ($urandom_range(99) < 25)
                        data_val = 8'($urandom_range(255));
                end
            endcase
            send_request(data_val, i == len - 1);
        end
    endtask

    // Random streams until about the given number of requests went in. Most
    // are well-formed streams of useful length; one in ten is a short one- or
    // two-byte stream that only opens and closes the code stream.
    task automatic run_phase(input int items, input bit mid_pause);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(9) == 0)
                len = $urandom_range(1, 2);
            else
                len = $urandom_range(6, 30);
            send_stream(len, $urandom_range(2), (mid_pause && sent == 0) ? len / 2 : -1);
            sent += len;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. The block first runs its clearing pass; the sender
        // simply waits for ready.
        send_idle_pct = 6;
        recv_idle_pct = 48;

        // One-byte streams at both ends of the byte range: clear code, the
        // byte, the end code and the flushed partial byte.
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b1);

        // A run of one byte: more and more lookups hit and the prefix chain
        // grows. This stream also shows that the block restarted after the
        // previous last byte.
        for (int i = 0; i < 7; i++)
            send_request(8'h41, i == 6);

        // Two alternating extremes: the pair codes come back as hits.
        for (int i = 0; i < 6; i++)
            send_request((i % 2 == 0) ? 8'h00 : 8'hFF, i == 5);

        // Walking bit patterns so every input bit takes both values.
        send_request(8'h80, 1'b0);
        send_request(8'h7F, 1'b0);
        send_request(8'h55, 1'b0);
        send_request(8'hAA, 1'b0);
        send_request(8'h01, 1'b0);
        send_request(8'hFE, 1'b1);

        // Random part, first with a mostly busy sender and a slow receiver.
        // The first stream of this phase stops halfway until the block has
        // caught up completely.
        run_phase(60, 1'b1);
        wait_for_drain();

        // Then a slow sender and a mostly busy receiver.
        send_idle_pct = 48;
        recv_idle_pct = 6;
        run_phase(60, 1'b0);
        wait_for_drain();

        // Finally neither side idles.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(60, 1'b0);

        wait_for_drain();

        if (tracker.error_count == 0 && tracker.owed_bytes.size() == 0)
            $display("PASS lzw_compressor_variable_width_top");
        else
            $display("FAIL lzw_compressor_variable_width_top");
        $finish;
    end

endmodule
